>>> src/llh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llh_pkg - shared definitions for the log-linear latency histogram
// Store geometry, field widths, mode codes, control/status structs, helpers.
// ----------------------------------------------------------------------------
package llh_pkg;

    localparam int SUB_BUCKET_BITS = 10;
    localparam int BUCKET_COUNT    = 27;

    localparam int VAL_W      = 64;
    localparam int Q_W        = 17;
    localparam int MODE_W     = 2;
    localparam int Q_FRAC     = 16;

    localparam int HALF_BITS  = SUB_BUCKET_BITS - 1;
    localparam int HALF_SLOTS = 1 << HALF_BITS;
    localparam int DEPTH      = (BUCKET_COUNT + 1) * HALF_SLOTS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int HI_W       = ADDR_W - HALF_BITS;
    localparam int BKT_W      = $clog2(VAL_W - SUB_BUCKET_BITS + 1);
    localparam int IDX_W      = BKT_W + HALF_BITS + 1;

    // rank = ceil(q * total / 2^Q_FRAC), product built from two half-width multiplies
    localparam int MUL_W      = VAL_W / 2;
    localparam int PROD_W     = Q_W + MUL_W;
    localparam int SUM_W      = Q_W + VAL_W;

    localparam int IN_DATA_W  = ((VAL_W + Q_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 5 * VAL_W;

    localparam logic [Q_W-1:0]   Q_ONE      = Q_W'(1 << Q_FRAC);
    localparam logic [SUM_W-1:0] RANK_ROUND = SUM_W'((1 << Q_FRAC) - 1);

    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic latch_in;
        logic enc;
        logic stats_clear;
        logic clr_start;
        logic clr_step;
        logic rec_rd;
        logic rec_wr;
        logic mul_lo;
        logic mul_hi;
        logic rank;
        logic clamp;
        logic scan_start;
        logic scan_step;
        logic top;
        logic qv_max;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              total_zero;
        logic              clr_last;
        logic              scan_hit;
        logic              scan_end;
    } t_status;

    // bucket = position of leading one of (v | sub mask) minus HALF_BITS
    function automatic logic [BKT_W-1:0] f_bucket(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] w;
        int pos;
        w   = v | VAL_W'((1 << SUB_BUCKET_BITS) - 1);
        pos = 0;
        for (int i = 0; i < VAL_W; i++) begin
            if (w[i]) begin
                pos = i;
            end
        end
        return BKT_W'(pos - HALF_BITS);
    endfunction

    function automatic logic [VAL_W-1:0] f_sat_add(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> src/log_linear_latency_histogram_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// log_linear_latency_histogram_core - log-linear latency histogram
// Records samples into a 14336-entry count store; answers quantile queries.
//
//   channel  dir  payload (low bit first)
//   s_axis   in   tuser: mode[1:0]; tdata: sample_value[63:0],
//                 quantile_q16[80:64], zero pad [87:81]
//   m_axis   out  tdata: quantile_value, total_samples, smallest_sample,
//                 largest_sample, sample_sum (64 bits each)
//
// One item at a time. Record: accept, bucket encode, store read, store write,
// result load. Query: accept, multiply, rank, clamp, scan of each slot up to and
// including the rank slot (at most 14336), top of slot, result load; an empty
// query skips to the result load. Clear sweeps the store. After reset a sweep
// zeroes the store before s_axis_tready. A held result stalls only the result load step.
// ----------------------------------------------------------------------------
module log_linear_latency_histogram_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // sample_value, quantile_q16, pad
    input  wire logic [llh_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode
    input  wire logic [llh_pkg::MODE_W-1:0]          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // quantile_value, total_samples, smallest_sample, largest_sample, sample_sum
    output logic [llh_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);
    import llh_pkg::*;

    t_cmd    cmd;
    t_status status;

    llh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    llh_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_mode   (s_axis_tuser),
        .i_sample (s_axis_tdata[VAL_W-1:0]),
        .i_quant  (s_axis_tdata[VAL_W +: Q_W]),
        .o_status (status),
        .o_result (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> src/llh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llh_ctrl - histogram sequencer
// Steps each item through record, query scan or clear sweep; owns handshakes.
// ----------------------------------------------------------------------------
module llh_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output llh_pkg::t_cmd        o_cmd,
    input  wire llh_pkg::t_status i_status
);
    import llh_pkg::*;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_REC_RD   = 4'd3;
    localparam logic [3:0] S_REC_WR   = 4'd4;
    localparam logic [3:0] S_Q_MLO    = 4'd5;
    localparam logic [3:0] S_Q_MHI    = 4'd6;
    localparam logic [3:0] S_Q_RANK   = 4'd7;
    localparam logic [3:0] S_Q_CLAMP  = 4'd8;
    localparam logic [3:0] S_Q_SCAN   = 4'd9;
    localparam logic [3:0] S_Q_TOP    = 4'd10;
    localparam logic [3:0] S_CLEAR    = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_INIT, S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.enc = 1'b1;
                case (i_status.mode)
                    MODE_RECORD: n_state = S_REC_RD;
                    MODE_QUERY:  n_state = i_status.total_zero ? S_DONE : S_Q_MLO;
                    MODE_CLEAR: begin
                        o_cmd.stats_clear = 1'b1;
                        o_cmd.clr_start   = 1'b1;
                        n_state           = S_CLEAR;
                    end
                    default:     n_state = S_DONE;
                endcase
            end
            S_REC_RD: begin
                o_cmd.rec_rd = 1'b1;
                n_state      = S_REC_WR;
            end
            S_REC_WR: begin
                o_cmd.rec_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_Q_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_Q_MHI;
            end
            S_Q_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_Q_RANK;
            end
            S_Q_RANK: begin
                o_cmd.rank = 1'b1;
                n_state    = S_Q_CLAMP;
            end
            S_Q_CLAMP: begin
                o_cmd.clamp      = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = S_Q_SCAN;
            end
            S_Q_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_hit) begin
                    n_state = S_Q_TOP;
                end else if (i_status.scan_end) begin
                    // rank never reached: report the running max
                    o_cmd.qv_max = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_Q_TOP: begin
                o_cmd.top = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> src/llh_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llh_dp - histogram datapath
// Count store, slot mapping, statistics, rank multiplier, scan and result reg.
// ----------------------------------------------------------------------------
module llh_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire llh_pkg::t_cmd                      i_cmd,
    input  wire logic [llh_pkg::MODE_W-1:0]         i_mode,
    input  wire logic [llh_pkg::VAL_W-1:0]          i_sample,
    input  wire logic [llh_pkg::Q_W-1:0]            i_quant,
    output llh_pkg::t_status                        o_status,
    output logic [llh_pkg::OUT_DATA_W-1:0]          o_result
);
    import llh_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    logic [MODE_W-1:0]     r_mode;
    logic [VAL_W-1:0]      r_val;
    logic [Q_W-1:0]        r_q;
    logic [BKT_W-1:0]      r_bkt;
    logic [ADDR_W-1:0]     r_widx;
    logic [VAL_W-1:0]      r_total, r_sum, r_min, r_max;
    logic [PROD_W-1:0]     r_plo, r_phi;
    logic [VAL_W-1:0]      r_rank;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_scan_more;
    logic                  r_rd_vld;
    logic [ADDR_W-1:0]     r_rd_idx;
    logic [VAL_W-1:0]      r_seen;
    logic [ADDR_W-1:0]     r_hit_idx;
    logic [VAL_W-1:0]      r_qv;
    logic [VAL_W-1:0]      r_rd_data;
    logic [OUT_DATA_W-1:0] r_result;

    logic [VAL_W-1:0]           sub_val;
    logic [IDX_W-1:0]           idx_full;
    logic [ADDR_W-1:0]          rec_idx;
    logic [ADDR_W-1:0]          rd_addr, wr_addr;
    logic                       rd_en, wr_en;
    logic [VAL_W-1:0]           wr_data;
    logic [MUL_W-1:0]           mul_b;
    logic [PROD_W-1:0]          mul_p;
    logic [SUM_W-1:0]           prod_sum;
    logic [VAL_W-1:0]           seen_n;
    logic                       scan_hit;
    logic                       addr_last;
    logic [HI_W-1:0]            top_hi, top_sh;
    logic [HALF_BITS-1:0]       top_lo;
    logic [VAL_W-1:0]           top_val;

    // slot index: bucket * half_slots + sub, which folds the half-slot offset
    assign sub_val  = r_val >> r_bkt;
    assign idx_full = (IDX_W'(r_bkt) << HALF_BITS) + IDX_W'(sub_val[SUB_BUCKET_BITS-1:0]);
    assign rec_idx  = (idx_full >= IDX_W'(DEPTH)) ? ADDR_W'(DEPTH - 1)
                                                  : idx_full[ADDR_W-1:0];

    assign addr_last = (r_addr == ADDR_W'(DEPTH - 1));

    assign rd_en   = i_cmd.rec_rd || (i_cmd.scan_step && r_scan_more);
    assign rd_addr = i_cmd.rec_rd ? rec_idx : r_addr;
    assign wr_en   = i_cmd.rec_wr || i_cmd.clr_step;
    assign wr_addr = i_cmd.rec_wr ? r_widx : r_addr;
    assign wr_data = i_cmd.rec_wr ? f_sat_add(r_rd_data, VAL_W'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // shared 17x32 multiplier, low half of total then high half
    assign mul_b    = i_cmd.mul_hi ? r_total[VAL_W-1:MUL_W] : r_total[MUL_W-1:0];
    assign mul_p    = PROD_W'(r_q) * PROD_W'(mul_b);
    assign prod_sum = (SUM_W'(r_phi) << MUL_W) + SUM_W'(r_plo) + RANK_ROUND;

    assign seen_n   = f_sat_add(r_seen, r_rd_data);
    assign scan_hit = r_rd_vld && (seen_n >= r_rank);

    // top of slot: floor | (slot width - 1); linear slots of bucket zero are width one
    assign top_hi  = r_hit_idx[ADDR_W-1:HALF_BITS];
    assign top_lo  = r_hit_idx[HALF_BITS-1:0];
    assign top_sh  = top_hi - HI_W'(1);
    assign top_val = (top_hi == '0) ? VAL_W'(top_lo)
                   : ((VAL_W'({1'b1, top_lo}) << top_sh)
                      | ((VAL_W'(1) << top_sh) - VAL_W'(1)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode <= i_mode;
            r_val  <= (i_sample == '0) ? VAL_W'(1) : i_sample;
            r_q    <= (i_quant > Q_ONE) ? Q_ONE : i_quant;
        end
        if (i_cmd.enc) begin
            r_bkt <= f_bucket(r_val);
        end
        if (i_cmd.rec_rd) begin
            r_widx <= rec_idx;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= mul_p;
        end
        if (i_cmd.rank) begin
            r_rank <= prod_sum[Q_FRAC +: VAL_W];
        end else if (i_cmd.clamp) begin
            if (r_rank == '0) begin
                r_rank <= VAL_W'(1);
            end else if (r_rank > r_total) begin
                r_rank <= r_total;
            end
        end
        if (i_cmd.scan_start) begin
            r_seen <= '0;
        end else if (i_cmd.scan_step && r_rd_vld) begin
            r_seen <= seen_n;
        end
        if (i_cmd.scan_step) begin
            r_rd_idx <= r_addr;
            if (scan_hit) begin
                r_hit_idx <= r_rd_idx;
            end
        end
        if (i_cmd.latch_in) begin
            r_qv <= '0;
        end else if (i_cmd.top) begin
            r_qv <= top_val;
        end else if (i_cmd.qv_max) begin
            r_qv <= r_max;
        end
        if (i_cmd.out_load) begin
            r_result <= {r_sum, r_max, r_min, r_total, r_qv};
        end
    end

    // control state and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_scan_more <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_total     <= '0;
            r_sum       <= '0;
            r_min       <= '1;
            r_max       <= '0;
        end else begin
            if (i_cmd.clr_start || i_cmd.scan_start) begin
                r_addr <= '0;
            end else if (i_cmd.clr_step || (i_cmd.scan_step && r_scan_more)) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_scan_more <= 1'b1;
                r_rd_vld    <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= r_scan_more;
                if (r_scan_more && addr_last) begin
                    r_scan_more <= 1'b0;
                end
            end
            if (i_cmd.stats_clear) begin
                r_total <= '0;
                r_sum   <= '0;
                r_min   <= '1;
                r_max   <= '0;
            end else if (i_cmd.rec_rd) begin
                r_total <= f_sat_add(r_total, VAL_W'(1));
                r_sum   <= f_sat_add(r_sum, r_val);
                if (r_val < r_min) begin
                    r_min <= r_val;
                end
                if (r_val > r_max) begin
                    r_max <= r_val;
                end
            end
        end
    end

    assign o_status.mode       = r_mode;
    assign o_status.total_zero = (r_total == '0);
    assign o_status.clr_last   = addr_last;
    assign o_status.scan_hit   = scan_hit;
    assign o_status.scan_end   = !r_scan_more && !r_rd_vld;
    assign o_result            = r_result;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - log-linear latency histogram core testbench
// Streams record, query, clear and idle transfers into the core, and predicts
// each result from a local copy of the slot counts and running statistics.
// Every result is checked field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import llh_pkg::*;

    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd3;
    localparam int                QUIET_LIMIT = 60000;
    localparam int                TAIL_CYCLES = 32;
    localparam int                HOLD_AFTER  = 200;
    localparam int                HOLD_CYCLES = 400;
    localparam logic [VAL_W-1:0]  ALL_ONES    = {VAL_W{1'b1}};

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  value;
        logic [Q_W-1:0]    q;
        bit                drain;
    } t_hist_op;

    // last field in the lowest bits
    typedef struct packed {
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] largest;
        logic [VAL_W-1:0] smallest;
        logic [VAL_W-1:0] total;
        logic [VAL_W-1:0] qvalue;
    } t_hist_stats;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;   // sample_value, quantile_q16, pad
    logic [MODE_W-1:0]      s_axis_tuser  = '0;   // mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;         // qvalue, total, min, max, sum

    log_linear_latency_histogram_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predicted histogram state
    logic [VAL_W-1:0] bin_count [DEPTH];
    logic [VAL_W-1:0] recorded_n;
    logic [VAL_W-1:0] sum_acc;
    logic [VAL_W-1:0] min_seen;
    logic [VAL_W-1:0] max_seen;

    t_hist_op    pending_ops[$];
    t_hist_stats expected_stats[$];

    int       mismatches   = 0;
    int       results_seen = 0;
    int       quiet_cycles = 0;
    logic     in_taken     = 1'b0;
    bit       drain_next   = 1'b0;

    int       tx_idle_left  = 0;
    bit       tx_calm       = 1'b0;
    t_hist_op cur_op;
    int       rx_stall_left = 0;
    int       rx_hold_left  = 0;
    bit       rx_hold_done  = 1'b0;
    bit       rx_calm       = 1'b0;
    logic     rx_holding    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void wipe_histogram();
        for (int i = 0; i < DEPTH; i++) begin
            bin_count[i] = '0;
        end
        recorded_n = '0;
        sum_acc    = '0;
        min_seen   = ALL_ONES;
        max_seen   = '0;
    endfunction

    function automatic logic [VAL_W-1:0] add_clamped(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? ALL_ONES : s[VAL_W-1:0];
    endfunction

    // bucket from the leading one of (v | sub-bucket mask)
    function automatic int bucket_of_sample(logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] w;
        int msb;
        w   = v | VAL_W'((1 << SUB_BUCKET_BITS) - 1);
        msb = 0;
        for (int i = 0; i < VAL_W; i++) begin
            if (w[i]) begin
                msb = i;
            end
        end
        return msb - HALF_BITS;
    endfunction

    function automatic int slot_of_sample(logic [VAL_W-1:0] v);
        int               b;
        logic [VAL_W-1:0] idx;
        b   = bucket_of_sample(v);
        idx = (VAL_W'(b + 1) << HALF_BITS) + (v >> b) - VAL_W'(HALF_SLOTS);
        if (idx >= VAL_W'(DEPTH)) begin
            idx = VAL_W'(DEPTH - 1);
        end
        return int'(idx);
    endfunction

    // highest value that lands in slot idx
    function automatic logic [VAL_W-1:0] slot_ceiling(int idx);
        int               hi;
        logic [VAL_W-1:0] low_edge;
        logic [VAL_W-1:0] w;
        hi       = idx >> HALF_BITS;
        low_edge = VAL_W'(idx & (HALF_SLOTS - 1));
        if (hi != 0) begin
            low_edge = (low_edge + VAL_W'(HALF_SLOTS)) << ((hi - 1) & 63);
        end
        w = VAL_W'(1) << bucket_of_sample(low_edge);
        return (low_edge & ~(w - 1)) + w - 1;
    endfunction

    function automatic logic [VAL_W-1:0] quantile_top(logic [Q_W-1:0] q_in);
        logic [VAL_W-1:0] q;
        logic [VAL_W-1:0] rank;
        logic [VAL_W-1:0] seen;
        int               i;
        if (recorded_n == 0) begin
            return '0;
        end
        q    = (q_in > Q_ONE) ? VAL_W'(Q_ONE) : VAL_W'(q_in);
        // exact ceil(q * total / 2^16) without a wide product
        rank = q * (recorded_n >> 16) + ((q * (recorded_n & 64'hFFFF) + 64'hFFFF) >> 16);
        if (rank == 0) begin
            rank = 1;
        end
        if (rank > recorded_n) begin
            rank = recorded_n;
        end
        seen = '0;
        for (i = 0; i < DEPTH; i++) begin
            seen = add_clamped(seen, bin_count[i]);
            if (seen >= rank) begin
                return slot_ceiling(i);
            end
        end
        return max_seen;
    endfunction

    function automatic t_hist_stats apply_op(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] v_in,
                                             logic [Q_W-1:0] q);
        t_hist_stats      r;
        logic [VAL_W-1:0] v;
        int               idx;
        r.qvalue = '0;
        case (mode)
            MODE_RECORD: begin
                v   = (v_in == 0) ? VAL_W'(1) : v_in;
                idx = slot_of_sample(v);
                bin_count[idx] = add_clamped(bin_count[idx], 1);
                recorded_n     = add_clamped(recorded_n, 1);
                sum_acc        = add_clamped(sum_acc, v);
                if (v < min_seen) begin
                    min_seen = v;
                end
                if (v > max_seen) begin
                    max_seen = v;
                end
            end
            MODE_QUERY: begin
                r.qvalue = quantile_top(q);
            end
            MODE_CLEAR: begin
                wipe_histogram();
            end
            default: begin
            end
        endcase
        r.total    = recorded_n;
        r.smallest = min_seen;
        r.largest  = max_seen;
        r.sum      = sum_acc;
        return r;
    endfunction

    function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int idle_len(bit calm);
        int p;
        if (calm) begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 55) begin
            return 0;
        end
        if (p < 85) begin
            return $urandom_range(1, 3);
        end
        if (p < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [VAL_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // profile 0: short latencies, 1: mostly short, 2: full range
    function automatic logic [VAL_W-1:0] rand_sample(int profile);
        int p;
        int w;
        p = $urandom_range(0, 99);
        if (p < 2) begin
            return '0;
        end
        if (p < 3 && profile != 0) begin
            return ALL_ONES;
        end
        if (p < 4 && profile != 0) begin
            return VAL_W'(1) << 63;
        end
        if (profile == 0) begin
            w = $urandom_range(0, 12);
        end else if (profile == 1 && p < 70) begin
            w = $urandom_range(0, 16);
        end else begin
            w = $urandom_range(0, 64);
        end
        return rand_word() >> (64 - w);
    endfunction

    function automatic logic [Q_W-1:0] rand_quantile();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10) begin
            return '0;
        end
        if (p < 20) begin
            return Q_ONE;
        end
        if (p < 30) begin
            return Q_W'($urandom_range(65537, 131071));
        end
        if (p < 50) begin
            return Q_W'($urandom_range(0, 4096));
        end
        if (p < 70) begin
            return Q_W'($urandom_range(60000, 65535));
        end
        return Q_W'($urandom_range(0, 65536));
    endfunction

    task automatic push_op(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] v, logic [Q_W-1:0] q);
        t_hist_op op;
        op.mode  = mode;
        op.value = v;
        op.q     = q;
        op.drain = drain_next;
        drain_next = 1'b0;
        pending_ops.push_back(op);
    endtask

    // ------------------------------------------------------------------------
    // sender: offers the pending operations, one NBA per signal per edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_ops
        logic offer;
        offer = s_axis_tvalid;
        if (i_rst_n) begin
            if (in_taken) begin
                offer = 1'b0;
                tx_idle_left = rx_holding ? 0 : idle_len(tx_calm);
                if ($urandom_range(0, 59) == 0) begin
                    tx_calm = !tx_calm;
                end
            end
            if (!offer) begin
                if (tx_idle_left > 0) begin
                    tx_idle_left--;
                end else if (pending_ops.size() != 0 &&
                             !(pending_ops[0].drain && expected_stats.size() != 0)) begin
                    cur_op = pending_ops.pop_front();
                    s_axis_tuser <= cur_op.mode;
                    s_axis_tdata <= IN_DATA_W'({cur_op.q, cur_op.value});
                    offer = 1'b1;
                end
            end
        end
        s_axis_tvalid <= offer;
    end

    // receiver: random stalls plus one long hold-off to back the core up
    always @(negedge i_clk) begin : accept_stats
        logic rdy;
        if (rx_hold_left > 0) begin
            rdy = 1'b0;
            rx_hold_left--;
        end else if (!rx_hold_done && results_seen >= HOLD_AFTER) begin
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_CYCLES;
            rdy = 1'b0;
        end else if (rx_stall_left > 0) begin
            rdy = 1'b0;
            rx_stall_left--;
        end else begin
            rdy = 1'b1;
            if (!rx_calm && $urandom_range(0, 2) == 0) begin
                rx_stall_left = idle_len(1'b0);
            end
            if ($urandom_range(0, 79) == 0) begin
                rx_calm = !rx_calm;
            end
        end
        m_axis_tready <= rdy;
        rx_holding    <= (rx_hold_left > 0);
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on input transfers, checks on output transfers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_streams
        t_hist_stats got;
        t_hist_stats want;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_hist_stats'(m_axis_tdata);
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("quantile_value", want.qvalue, got.qvalue);
                    check_field("total_samples", want.total, got.total);
                    check_field("smallest_sample", want.smallest, got.smallest);
                    check_field("largest_sample", want.largest, got.largest);
                    check_field("sample_sum", want.sum, got.sum);
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_stats.push_back(apply_op(s_axis_tuser, s_axis_tdata[VAL_W-1:0],
                                                  s_axis_tdata[VAL_W+Q_W-1:VAL_W]));
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : run
        int profile;
        int p;
        wipe_histogram();

        // directed: empty query, edge samples, sum saturation, quantile edges
        push_op(MODE_QUERY, rand_word(), Q_ONE);
        push_op(MODE_RECORD, '0, rand_quantile());
        push_op(MODE_RECORD, 64'd1, rand_quantile());
        push_op(MODE_RECORD, 64'd1023, rand_quantile());
        push_op(MODE_RECORD, 64'd1024, rand_quantile());
        push_op(MODE_RECORD, 64'd1 << 63, rand_quantile());     // past the last bucket
        push_op(MODE_RECORD, ALL_ONES, rand_quantile());       // sum saturates
        push_op(MODE_QUERY, rand_word(), '0);                  // rank raised to one
        push_op(MODE_QUERY, rand_word(), Q_ONE);
        push_op(MODE_QUERY, rand_word(), {Q_W{1'b1}});         // above one
        push_op(MODE_QUERY, rand_word(), Q_W'(32768));
        push_op(MODE_IDLE, ALL_ONES, {Q_W{1'b1}});
        push_op(MODE_RECORD, 64'h5555_5555_5555_5555, '0);
        push_op(MODE_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, {Q_W{1'b1}});
        push_op(MODE_QUERY, '0, Q_W'(16'hFFFF));
        drain_next = 1'b1;
        push_op(MODE_CLEAR, rand_word(), rand_quantile());
        push_op(MODE_QUERY, rand_word(), Q_W'(40000));         // empty after clear
        push_op(MODE_RECORD, 64'd7, rand_quantile());
        push_op(MODE_QUERY, rand_word(), Q_ONE);
        push_op(MODE_IDLE, '0, '0);
        push_op(MODE_CLEAR, rand_word(), rand_quantile());

        // random phases; each starts only once the core has drained
        for (int ph = 0; ph < 8; ph++) begin
            profile    = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 1 : 2);
            drain_next = 1'b1;
            if (ph % 3 != 2) begin
                push_op(MODE_CLEAR, rand_word(), rand_quantile());
            end
            for (int n = 0; n < 100; n++) begin
                p = $urandom_range(0, 999);
                if (p < 5) begin
                    push_op(MODE_CLEAR, rand_word(), rand_quantile());
                end else if (p < 25) begin
                    push_op(MODE_IDLE, rand_word(), rand_quantile());
                end else if (p < 125) begin
                    push_op(MODE_QUERY, rand_word(), rand_quantile());
                end else begin
                    push_op(MODE_RECORD, rand_sample(profile), rand_quantile());
                end
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid || expected_stats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/llh_pkg.sv
src/llh_ctrl.sv
src/llh_dp.sv
src/log_linear_latency_histogram_core.sv
tb/sv/tb.sv
